>>> design/nca_pkg.sv
// constants and types for the normal cdf approximation pipeline
package nca_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_MEAN = 2'd0;
  localparam cfg_idx_t REG_DEV  = 2'd1;

  // |z| saturation, 16.0 in q16.16
  localparam logic [20:0] ZSAT = 21'h10_0000;

  // 0.2316419 in q0.30
  localparam logic [27:0] COEF_P = 28'd248723596;

  // horner coefficients in q2.30, signed
  localparam int S_W = 35;
  typedef logic signed [S_W-1:0] poly_t;
  localparam poly_t COEF_B5 = 35'sd1428371292;
  localparam poly_t HCOEF [5] = '{
    -35'sd1955558716,
     35'sd1912847369,
    -35'sd382857446,
     35'sd342933307,
     35'sd0
  };

  // exact reciprocal multipliers for 32-bit operands
  localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  localparam logic [32:0] ONE32 = 33'h1_0000_0000;
  localparam logic [32:0] ONE30 = 33'h0_4000_0000;

  // 1/sqrt(2*pi) in q0.30
  localparam logic [28:0] INV_SQRT_2PI = 29'd428361012;

  localparam logic [16:0] PROB_ONE = 17'd65536;

endpackage

>>> design/normal_cdf_approx.sv
// normal cdf approximation: top level and full pipeline
//
// Takes a signed q16.16 sample and returns the normal cumulative probability
// as unsigned q1.16 (65536 means 1.0), using z = (sample - mean_value) /
// deviation and the five-term polynomial in k = 1/(1 + 0.2316419|z|) times
// the gaussian density. The block is one straight pipeline of 93 register
// stages with no feedback: one sample is taken per cycle while sample_stall
// is low, and every sample gives exactly one probability. The depth is set
// by the two restoring dividers, one quotient bit per stage (21 stages for
// |z|, 31 stages for k), followed by the horner chain, the exponential
// series and ten squaring stages. Each stage advances when the next stage
// is empty or advancing, so bubbles close up and a held result at the
// output stops new samples only once every stage is full. Configuration
// writes are taken in every cycle and must only happen while the pipeline
// is empty. A zero deviation acts as one lsb.
module normal_cdf_approx
  import nca_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [31:0] sample,
  // result channel
  output logic               probability_valid,
  input  logic               probability_stall,
  output logic [16:0]        probability,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfg_idx_t           cfg_index,
  input  logic [31:0]        cfg_data
);

  // stage map
  localparam int V1N   = 21;
  localparam int V2N   = 31;
  localparam int HN    = 5;
  localparam int EN    = 12;
  localparam int SQN   = 10;
  localparam int S_D   = 0;
  localparam int S_M   = S_D + 1;
  localparam int S_S   = S_M + 1;
  localparam int S_V1  = S_S + 1;
  localparam int S_ZA  = S_V1 + V1N;
  localparam int S_PZ  = S_ZA + 1;
  localparam int S_DEN = S_PZ + 1;
  localparam int S_V2  = S_DEN + 1;
  localparam int S_HP  = S_V2 + V2N;
  localparam int S_E   = S_HP + 2 * HN;
  localparam int S_SQ  = S_E + EN;
  localparam int S_DN  = S_SQ + SQN;
  localparam int S_TM  = S_DN + 1;
  localparam int S_OUT = S_TM + 1;
  localparam int NS    = S_OUT + 1;

  // configuration registers
  logic signed [31:0] mean_value;
  logic [30:0]        deviation;
  logic [30:0]        dev_eff;

  assign cfg_ready = 1'b1;
  assign dev_eff   = (deviation == 31'd0) ? 31'd1 : deviation;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_value <= '0;
      deviation  <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MEAN: mean_value <= cfg_data;
        REG_DEV:  deviation  <= cfg_data[30:0];
        default:  ;
      endcase
    end
  end

  // stage valids and advance enables
  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic [NS-1:0] v_prev;

  always_comb begin
    en[NS-1] = !v[NS-1] || !probability_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign v_prev       = {v[NS-2:0], sample_valid};
  assign sample_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v_prev[i];
        end
      end
    end
  end

  // front: difference, magnitude, saturation check
  logic signed [32:0] d_q;
  logic               m_neg;
  logic [32:0]        m_mag;
  logic               s_sat;
  logic               s_neg;
  logic [30:0]        s_rem;
  logic [4:0]         s_mlo;

  always_ff @(posedge clk) begin
    if (en[S_D]) begin
      d_q <= 33'(sample) - 33'(mean_value);
    end
    if (en[S_M]) begin
      m_neg <= d_q[32];
      m_mag <= d_q[32] ? 33'(-d_q) : 33'(d_q);
    end
    if (en[S_S]) begin
      // quotient would reach 2^21, far past the saturation point
      s_sat <= {3'b000, m_mag} >= {dev_eff, 5'b00000};
      s_neg <= m_neg;
      s_rem <= 31'(m_mag[32:5]);
      s_mlo <= m_mag[4:0];
    end
  end

  // |z| divider, one quotient bit per stage
  logic [30:0] v1_rem [V1N];
  logic [20:0] v1_q   [V1N];
  logic        v1_sat [V1N];
  logic        v1_neg [V1N];
  logic [4:0]  v1_mlo [V1N];

  logic [30:0] d1_rem_in [V1N];
  logic [20:0] d1_q_in   [V1N];
  logic        d1_sat_in [V1N];
  logic        d1_neg_in [V1N];
  logic [4:0]  d1_mlo_in [V1N];
  logic [31:0] d1_trial  [V1N];
  logic        d1_ge     [V1N];

  always_comb begin
    for (int t = 0; t < V1N; t++) begin
      if (t == 0) begin
        d1_rem_in[t] = s_rem;
        d1_q_in[t]   = '0;
        d1_sat_in[t] = s_sat;
        d1_neg_in[t] = s_neg;
        d1_mlo_in[t] = s_mlo;
      end else begin
        d1_rem_in[t] = v1_rem[t-1];
        d1_q_in[t]   = v1_q[t-1];
        d1_sat_in[t] = v1_sat[t-1];
        d1_neg_in[t] = v1_neg[t-1];
        d1_mlo_in[t] = v1_mlo[t-1];
      end
      d1_trial[t] = {d1_rem_in[t], d1_mlo_in[t][4]};
      d1_ge[t]    = d1_trial[t] >= {1'b0, dev_eff};
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < V1N; t++) begin
      if (en[S_V1+t]) begin
        v1_rem[t] <= d1_ge[t] ? 31'(d1_trial[t] - {1'b0, dev_eff}) : d1_trial[t][30:0];
        v1_q[t]   <= {d1_q_in[t][19:0], d1_ge[t]};
        v1_sat[t] <= d1_sat_in[t];
        v1_neg[t] <= d1_neg_in[t];
        v1_mlo[t] <= {d1_mlo_in[t][3:0], 1'b0};
      end
    end
  end

  // saturated |z| and the k denominator
  logic [20:0] za;
  logic        za_neg;
  logic [48:0] pz;
  logic [20:0] pz_za;
  logic        pz_neg;
  logic [32:0] den;
  logic [20:0] den_za;
  logic        den_neg;

  always_ff @(posedge clk) begin
    if (en[S_ZA]) begin
      za     <= (v1_sat[V1N-1] || v1_q[V1N-1] > ZSAT) ? ZSAT : v1_q[V1N-1];
      za_neg <= v1_neg[V1N-1];
    end
    if (en[S_PZ]) begin
      pz     <= 49'(COEF_P) * 49'(za);
      pz_za  <= za;
      pz_neg <= za_neg;
    end
    if (en[S_DEN]) begin
      den     <= ONE30 + pz[48:16];
      den_za  <= pz_za;
      den_neg <= pz_neg;
    end
  end

  // k divider: round(2^60 / den), one quotient bit per stage
  logic [32:0] v2_rem [V2N];
  logic [30:0] v2_q   [V2N];
  logic [32:0] v2_den [V2N];
  logic [30:0] v2_nb  [V2N];
  logic [20:0] v2_za  [V2N];
  logic        v2_neg [V2N];

  logic [32:0] d2_rem_in [V2N];
  logic [30:0] d2_q_in   [V2N];
  logic [32:0] d2_den_in [V2N];
  logic [30:0] d2_nb_in  [V2N];
  logic [20:0] d2_za_in  [V2N];
  logic        d2_neg_in [V2N];
  logic [33:0] d2_trial  [V2N];
  logic        d2_ge     [V2N];

  always_comb begin
    for (int t = 0; t < V2N; t++) begin
      if (t == 0) begin
        // numerator top bits: 2^29 plus the top bit of den/2
        d2_rem_in[t] = 33'h0_2000_0000 + 33'(den[32]);
        d2_q_in[t]   = '0;
        d2_den_in[t] = den;
        d2_nb_in[t]  = den[31:1];
        d2_za_in[t]  = den_za;
        d2_neg_in[t] = den_neg;
      end else begin
        d2_rem_in[t] = v2_rem[t-1];
        d2_q_in[t]   = v2_q[t-1];
        d2_den_in[t] = v2_den[t-1];
        d2_nb_in[t]  = v2_nb[t-1];
        d2_za_in[t]  = v2_za[t-1];
        d2_neg_in[t] = v2_neg[t-1];
      end
      d2_trial[t] = {d2_rem_in[t], d2_nb_in[t][30]};
      d2_ge[t]    = d2_trial[t] >= {1'b0, d2_den_in[t]};
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < V2N; t++) begin
      if (en[S_V2+t]) begin
        v2_rem[t] <= d2_ge[t] ? 33'(d2_trial[t] - {1'b0, d2_den_in[t]})
                              : d2_trial[t][32:0];
        v2_q[t]   <= {d2_q_in[t][29:0], d2_ge[t]};
        v2_den[t] <= d2_den_in[t];
        v2_nb[t]  <= {d2_nb_in[t][29:0], 1'b0};
        v2_za[t]  <= d2_za_in[t];
        v2_neg[t] <= d2_neg_in[t];
      end
    end
  end

  // horner chain: multiply stage then add stage per coefficient
  logic [64:0] hp_prod [HN];
  logic        hp_sgn  [HN];
  logic [30:0] hp_k    [HN];
  logic [20:0] hp_za   [HN];
  logic        hp_neg  [HN];
  poly_t       ha_s    [HN];
  logic [30:0] ha_k    [HN];
  logic [20:0] ha_za   [HN];
  logic        ha_neg  [HN];

  poly_t       hp_s_in   [HN];
  logic [30:0] hp_k_in   [HN];
  logic [20:0] hp_za_in  [HN];
  logic        hp_neg_in [HN];
  logic [33:0] hp_mag    [HN];
  poly_t       ha_term   [HN];

  always_comb begin
    for (int j = 0; j < HN; j++) begin
      if (j == 0) begin
        hp_s_in[j]   = COEF_B5;
        hp_k_in[j]   = v2_q[V2N-1];
        hp_za_in[j]  = v2_za[V2N-1];
        hp_neg_in[j] = v2_neg[V2N-1];
      end else begin
        hp_s_in[j]   = ha_s[j-1];
        hp_k_in[j]   = ha_k[j-1];
        hp_za_in[j]  = ha_za[j-1];
        hp_neg_in[j] = ha_neg[j-1];
      end
      hp_mag[j]  = hp_s_in[j][S_W-1] ? 34'(-hp_s_in[j]) : 34'(hp_s_in[j]);
      // truncate toward zero: shift the magnitude, then restore the sign
      ha_term[j] = hp_sgn[j] ? -$signed({1'b0, hp_prod[j][63:30]})
                             : $signed({1'b0, hp_prod[j][63:30]});
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < HN; j++) begin
      if (en[S_HP+2*j]) begin
        hp_prod[j] <= 65'(hp_mag[j]) * 65'(hp_k_in[j]);
        hp_sgn[j]  <= hp_s_in[j][S_W-1];
        hp_k[j]    <= hp_k_in[j];
        hp_za[j]   <= hp_za_in[j];
        hp_neg[j]  <= hp_neg_in[j];
      end
      if (en[S_HP+2*j+1]) begin
        ha_s[j]   <= HCOEF[j] + ha_term[j];
        ha_k[j]   <= hp_k[j];
        ha_za[j]  <= hp_za[j];
        ha_neg[j] <= hp_neg[j];
      end
    end
  end

  // exponential series: h = 1 - r*h/n for n = 5..1, r = z^2/2048
  logic [29:0] e_r   [EN];
  logic [33:0] e_ks  [EN];
  logic        e_neg [EN];
  logic [63:0] e_w   [EN];
  logic [41:0] e_zz;

  assign e_zz = 42'(ha_za[HN-1]) * 42'(ha_za[HN-1]);

  always_ff @(posedge clk) begin
    for (int t = 0; t < EN; t++) begin
      if (en[S_E+t]) begin
        if (t == 0) begin
          e_r[t]   <= e_zz[40:11];
          // a negative tail sum counts as zero
          e_ks[t]  <= ha_s[HN-1][S_W-1] ? 34'd0 : ha_s[HN-1][33:0];
          e_neg[t] <= ha_neg[HN-1];
        end else begin
          e_r[t]   <= e_r[t-1];
          e_ks[t]  <= e_ks[t-1];
          e_neg[t] <= e_neg[t-1];
        end
      end
    end
    if (en[S_E+0])  e_w[0]  <= 64'(e_zz[40:11]);
    if (en[S_E+1])  e_w[1]  <= 64'(e_r[0]) * 64'(RECIP5);
    if (en[S_E+2])  e_w[2]  <= 64'(ONE32 - 33'(e_w[1][61:34]));
    if (en[S_E+3])  e_w[3]  <= 64'(e_r[2]) * 64'(e_w[2][32:0]);
    if (en[S_E+4])  e_w[4]  <= 64'(ONE32 - 33'(e_w[3][63:34]));
    if (en[S_E+5])  e_w[5]  <= 64'(e_r[4]) * 64'(e_w[4][32:0]);
    if (en[S_E+6])  e_w[6]  <= 64'(e_w[5][63:32]) * 64'(RECIP3);
    if (en[S_E+7])  e_w[7]  <= 64'(ONE32 - 33'(e_w[6][63:33]));
    if (en[S_E+8])  e_w[8]  <= 64'(e_r[7]) * 64'(e_w[7][32:0]);
    if (en[S_E+9])  e_w[9]  <= 64'(ONE32 - 33'(e_w[8][63:33]));
    if (en[S_E+10]) e_w[10] <= 64'(e_r[9]) * 64'(e_w[9][32:0]);
    if (en[S_E+11]) e_w[11] <= 64'(ONE32 - 33'(e_w[10][63:32]));
  end

  // ten squarings raise the series result to the 1024th power
  logic [32:0] sq_h   [SQN];
  logic [33:0] sq_ks  [SQN];
  logic        sq_neg [SQN];
  logic [32:0] sq_in  [SQN];
  logic [65:0] sq_p   [SQN];

  always_comb begin
    for (int t = 0; t < SQN; t++) begin
      sq_in[t] = (t == 0) ? e_w[EN-1][32:0] : sq_h[(t == 0) ? 0 : t - 1];
      sq_p[t]  = 66'(sq_in[t]) * 66'(sq_in[t]);
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < SQN; t++) begin
      if (en[S_SQ+t]) begin
        sq_h[t] <= (sq_in[t] == ONE32) ? ONE32 : sq_p[t][64:32];
        if (t == 0) begin
          sq_ks[t]  <= e_ks[EN-1];
          sq_neg[t] <= e_neg[EN-1];
        end else begin
          sq_ks[t]  <= sq_ks[t-1];
          sq_neg[t] <= sq_neg[t-1];
        end
      end
    end
  end

  // density, tail product, rounding and sign fold
  logic [61:0] dn_p;
  logic [28:0] dens;
  logic [33:0] dn_ks;
  logic        dn_neg;
  logic [62:0] tm_p;
  logic [32:0] t30;
  logic        tm_neg;
  logic [33:0] t_sum;
  logic [19:0] t16_raw;
  logic [16:0] t16;
  logic [16:0] prob;

  assign dn_p    = 62'(INV_SQRT_2PI) * 62'(sq_h[SQN-1]);
  assign tm_p    = 63'(dens) * 63'(dn_ks);
  assign t_sum   = {1'b0, t30} + 34'd8192;
  assign t16_raw = t_sum[33:14];
  assign t16     = (t16_raw > 20'(PROB_ONE)) ? PROB_ONE : t16_raw[16:0];

  always_ff @(posedge clk) begin
    if (en[S_DN]) begin
      dens   <= dn_p[60:32];
      dn_ks  <= sq_ks[SQN-1];
      dn_neg <= sq_neg[SQN-1];
    end
    if (en[S_TM]) begin
      t30    <= tm_p[62:30];
      tm_neg <= dn_neg;
    end
    if (en[S_OUT]) begin
      prob <= tm_neg ? t16 : PROB_ONE - t16;
    end
  end

  assign probability       = prob;
  assign probability_valid = v[S_OUT];

  // a saturated division must leave |z| at the clamp value
  a_za_sat: assert property (@(posedge clk) disable iff (rst)
    en[S_ZA] && v[S_ZA-1] && v1_sat[V1N-1] |=> za == ZSAT)
    else $error("saturated |z| not clamped");

  // |z| divider remainder stays below the divisor
  a_rem1: assert property (@(posedge clk) disable iff (rst)
    v[S_ZA-1] && !v1_sat[V1N-1] |-> v1_rem[V1N-1] < dev_eff)
    else $error("z divider remainder out of range");

  // k divider remainder stays below den
  a_rem2: assert property (@(posedge clk) disable iff (rst)
    v[S_HP-1] |-> v2_rem[V2N-1] < v2_den[V2N-1])
    else $error("k divider remainder out of range");

  // an accepted sample always lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> v[S_D])
    else $error("accepted sample lost");

  // the exponential never grows past one
  a_exp: assert property (@(posedge clk) disable iff (rst)
    v[S_DN-1] |-> sq_h[SQN-1] <= ONE32)
    else $error("exponential above one");

endmodule
